[rtl/bhrt_pkg.sv]
package bhrt_pkg;

  // Sizes
  localparam int BUTTON_COUNT = 7;
  localparam int PIN_W        = 7;
  localparam int MASK_W       = 7;
  localparam int QUERY_W      = 3;
  localparam int COUNT_W      = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int STEP_W       = $clog2(COUNT_W);

  // Counter codes
  localparam logic [COUNT_W-1:0] COUNT_IDLE = 8'h00;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = 8'h01;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'hFE;
  localparam logic [COUNT_W-1:0] REL_MARK   = 8'hFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 2'd1;

  // Register reset values
  localparam logic [COUNT_W-1:0] HOLD_TIME_RST     = 8'd20;
  localparam logic [COUNT_W-1:0] REPEAT_PERIOD_RST = 8'd1;

  // Sequencer to lanes
  typedef struct packed {
    logic start;
    logic step;
  } lane_ctrl_t;

  // Lane findings for the merge stage
  typedef struct packed {
    logic pressed;
    logic released;
    logic held;
    logic repeat_hit;
  } lane_flags_t;

endpackage

[rtl/bhrt_lane.sv]
module bhrt_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  bhrt_pkg::lane_ctrl_t              ctrl,
  input  logic                              down,
  input  logic [bhrt_pkg::COUNT_W-1:0]      hold_time,
  input  logic [bhrt_pkg::COUNT_W-1:0]      repeat_period,
  output logic [bhrt_pkg::COUNT_W-1:0]      count,
  output bhrt_pkg::lane_flags_t             flags
);
  import bhrt_pkg::*;

  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] dividend;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W:0]   trial;
  logic               held_now;

  // Next frame count: rise while down, mark on first up frame, then idle
  always_comb begin
    if (down) begin
      if (count == REL_MARK)       count_next = COUNT_ONE;
      else if (count >= COUNT_MAX) count_next = COUNT_MAX;
      else                         count_next = count + COUNT_ONE;
    end else begin
      if (count == COUNT_IDLE || count == REL_MARK) count_next = COUNT_IDLE;
      else                                          count_next = REL_MARK;
    end
  end

  // Frame counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= COUNT_IDLE;
    end else if (ctrl.start) begin
      count <= count_next;
    end
  end

  // Restoring remainder, one dividend bit per step
  assign trial = {rem, dividend[COUNT_W-1]};

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dividend <= count_next;
      rem      <= '0;
    end else if (ctrl.step) begin
      dividend <= {dividend[COUNT_W-2:0], 1'b0};
      if (trial >= {1'b0, repeat_period}) begin
        rem <= COUNT_W'(trial - {1'b0, repeat_period});
      end else begin
        rem <= trial[COUNT_W-1:0];
      end
    end
  end

  // Flags from the updated count
  assign held_now         = (count != COUNT_IDLE) && (count != REL_MARK);
  assign flags.pressed    = (count == COUNT_ONE);
  assign flags.released   = (count == REL_MARK);
  assign flags.held       = held_now && (count == hold_time);
  assign flags.repeat_hit = held_now && ((repeat_period <= COUNT_ONE) || (rem == COUNT_ONE));

endmodule

[rtl/bhrt_merge.sv]
module bhrt_merge (
  input  logic                             clk,
  input  logic                             load,
  input  bhrt_pkg::lane_flags_t            flags [bhrt_pkg::BUTTON_COUNT],
  input  logic [bhrt_pkg::COUNT_W-1:0]     counts [bhrt_pkg::BUTTON_COUNT],
  input  logic [bhrt_pkg::QUERY_W-1:0]     query_button,
  output logic [bhrt_pkg::MASK_W-1:0]      pressed_mask,
  output logic [bhrt_pkg::MASK_W-1:0]      released_mask,
  output logic [bhrt_pkg::MASK_W-1:0]      held_mask,
  output logic [bhrt_pkg::MASK_W-1:0]      repeat_mask,
  output logic [bhrt_pkg::COUNT_W-1:0]     hold_frames
);
  import bhrt_pkg::*;

  logic [MASK_W-1:0]  pm, rm, hm, am;
  logic [COUNT_W-1:0] sel_count;
  logic [COUNT_W-1:0] frames;

  // Gather lane flags into masks
  always_comb begin
    pm = '0;
    rm = '0;
    hm = '0;
    am = '0;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (i < MASK_W) begin
        pm[i] = flags[i].pressed;
        rm[i] = flags[i].released;
        hm[i] = flags[i].held;
        am[i] = flags[i].repeat_hit;
      end
    end
  end

  // Queried button's hold time; released mark and bad index read as zero
  always_comb begin
    sel_count = COUNT_IDLE;
    if (int'(query_button) < BUTTON_COUNT) begin
      sel_count = counts[query_button];
    end
    frames = (sel_count == REL_MARK) ? COUNT_IDLE : sel_count;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      pressed_mask  <= pm;
      released_mask <= rm;
      held_mask     <= hm;
      repeat_mask   <= am;
      hold_frames   <= frames;
    end
  end

endmodule

[rtl/button_hold_repeat_tracker.sv]
// Sequence: an item is accepted in ST_IDLE, then the 8-step remainder unit in each lane
// runs in ST_RUN (one dividend bit per cycle), then ST_DONE loads the result onto
// m_tvalid once the output register is free. No new item is taken before that load.
// A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous): all counters idle, hold_time 20, repeat_period 1.
module button_hold_repeat_tracker (
  input  logic        clk,
  input  logic        rst,
  // slave: [6:0] pin_levels, [9:7] query_button, [15:10] zero
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // master: [6:0] pressed_mask, [13:7] released_mask, [20:14] held_mask,
  //         [27:21] repeat_mask, [35:28] hold_frames, [39:36] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import bhrt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t             state;
  logic [STEP_W-1:0]  step_cnt;
  logic [COUNT_W-1:0] hold_time;
  logic [COUNT_W-1:0] repeat_period;
  logic [PIN_W-1:0]   pins;
  logic [QUERY_W-1:0] query;
  logic               accept;
  logic               load;
  lane_ctrl_t         ctrl;
  lane_flags_t        flags  [BUTTON_COUNT];
  logic [COUNT_W-1:0] counts [BUTTON_COUNT];
  logic [MASK_W-1:0]  pressed_mask, released_mask, held_mask, repeat_mask;
  logic [COUNT_W-1:0] hold_frames;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign load      = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign cfg_ready = 1'b1;
  assign pins      = s_tdata[PIN_W-1:0];

  assign ctrl.start = accept;
  assign ctrl.step  = (state == ST_RUN);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time     <= HOLD_TIME_RST;
      repeat_period <= REPEAT_PERIOD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HOLD_TIME:     hold_time     <= cfg_data;
        REG_REPEAT_PERIOD: repeat_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // a new result replaces one leaving in the same cycle
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state    <= ST_RUN;
            step_cnt <= '0;
          end
        end
        ST_RUN: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == STEP_W'(COUNT_W - 1)) state <= ST_DONE;
        end
        ST_DONE: begin
          if (load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Query held for the merge stage
  always_ff @(posedge clk) begin
    if (accept) query <= s_tdata[PIN_W +: QUERY_W];
  end

  // One lane per button
  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
    logic down;
    if (i < PIN_W) begin : g_pin
      assign down = ~pins[i];
    end else begin : g_nopin
      assign down = 1'b0;
    end

    bhrt_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .down          (down),
      .hold_time     (hold_time),
      .repeat_period (repeat_period),
      .count         (counts[i]),
      .flags         (flags[i])
    );
  end

  bhrt_merge u_merge (
    .clk           (clk),
    .load          (load),
    .flags         (flags),
    .counts        (counts),
    .query_button  (query),
    .pressed_mask  (pressed_mask),
    .released_mask (released_mask),
    .held_mask     (held_mask),
    .repeat_mask   (repeat_mask),
    .hold_frames   (hold_frames)
  );

  assign m_tdata = {4'b0, hold_frames, repeat_mask, held_mask, released_mask, pressed_mask};

  // Checks
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("item taken while lanes busy");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##9 (state == ST_DONE))
    else $error("remainder sequence length wrong");

  a_no_mark_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (hold_frames != REL_MARK))
    else $error("released mark reported as hold time");

  a_press_rel_disjoint: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((pressed_mask & released_mask) == '0))
    else $error("button both pressed and released");

endmodule
